>>> hdl/rotation_matrix_to_quaternion_core_assert.svh
// Assertion macros used by the checker file.
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_ASSERT_SVH

// Checked while out of reset.
`define RMQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RMQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hdl/rmq_pkg.sv
package rmq_pkg;
    localparam int FRAC_BITS = 14;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int LEN_GUARD = 10;
    localparam int MAG_W     = 17;             // largest |v| is 114687
    localparam int SUM_W     = 2 * MAG_W + 2;  // four squares
    localparam int RAD_W     = SUM_W + 2 * LEN_GUARD;
    localparam int SQ_STEPS  = RAD_W / 2;      // one root bit a stage
    localparam int LEN_W     = SQ_STEPS;
    localparam int REM_W     = LEN_W + 3;
    localparam int Q_W       = FRAC_BITS + 1;  // quotient never above ONE
    localparam int NUM_W     = MAG_W + FRAC_BITS + LEN_GUARD + 1;

    typedef logic [MAG_W-1:0] t_mag;

    typedef struct packed {
        t_mag [3:0] mag;
        logic [3:0] neg;
    } t_side;
endpackage

>>> hdl/rmq_if.sv
interface rmq_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    modport source (output valid, e00, e01, e02, e10, e11, e12, e20, e21, e22,
                    input ready);
    modport sink (input valid, e00, e01, e02, e10, e11, e12, e20, e21, e22,
                  output ready);
endinterface

interface rmq_out_if;
    logic valid;
    logic ready;
    logic signed [15:0] qx, qy, qz, qw;
    modport source (output valid, qx, qy, qz, qw, input ready);
    modport sink (input valid, qx, qy, qz, qw, output ready);
endinterface

>>> hdl/rmq_front.sv
// Branch choice, unnormalized vector, magnitudes, squares and their sum.
module rmq_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic signed [15:0]        i_e00, i_e01, i_e02,
    input  logic signed [15:0]        i_e10, i_e11, i_e12,
    input  logic signed [15:0]        i_e20, i_e21, i_e22,
    output logic                      o_valid,
    output logic [rmq_pkg::SUM_W-1:0] o_sum,
    output rmq_pkg::t_side            o_side
);
    typedef enum logic [1:0] {BR_TRACE, BR_X, BR_Y, BR_Z} t_branch;

    logic               r1_vld, r2_vld, r3_vld, r4_vld;
    logic signed [17:0] r1_tr, r1_rx, r1_ry, r1_rz;
    logic signed [16:0] r1_a12, r1_a20, r1_a01, r1_s01, r1_s02, r1_s12;
    logic               r1_c0, r1_c1;
    t_branch            n_br;
    logic signed [17:0] n_v [4];
    rmq_pkg::t_side     n_side, r2_side, r3_side, r4_side;
    logic [2*rmq_pkg::MAG_W-1:0] r3_sq [4];
    logic [rmq_pkg::SUM_W-1:0]   r4_sum;

    function automatic logic signed [17:0] clamp_pos(input logic signed [17:0] r);
        return (r < 18'sd1) ? 18'sd1 : r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    // stage 1: sums, differences, diagonal compares
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_tr  <= 18'(i_e00) + 18'(i_e11) + 18'(i_e22);
            r1_rx  <= 18'(rmq_pkg::ONE) + 18'(i_e00) - 18'(i_e11) - 18'(i_e22);
            r1_ry  <= 18'(rmq_pkg::ONE) + 18'(i_e11) - 18'(i_e00) - 18'(i_e22);
            r1_rz  <= 18'(rmq_pkg::ONE) + 18'(i_e22) - 18'(i_e11) - 18'(i_e00);
            r1_a12 <= 17'(i_e12) - 17'(i_e21);
            r1_a20 <= 17'(i_e20) - 17'(i_e02);
            r1_a01 <= 17'(i_e01) - 17'(i_e10);
            r1_s01 <= 17'(i_e10) + 17'(i_e01);
            r1_s02 <= 17'(i_e20) + 17'(i_e02);
            r1_s12 <= 17'(i_e21) + 17'(i_e12);
            r1_c0  <= (i_e00 > i_e11) && (i_e00 > i_e22);
            r1_c1  <= i_e11 > i_e22;
        end
    end

    // stage 2: pick the branch, split into sign and magnitude
    always_comb begin
        if (r1_tr > 18'sd0)  n_br = BR_TRACE;
        else if (r1_c0)      n_br = BR_X;
        else if (r1_c1)      n_br = BR_Y;
        else                 n_br = BR_Z;
        case (n_br)
            BR_TRACE: begin
                n_v[0] = 18'(r1_a12);
                n_v[1] = 18'(r1_a20);
                n_v[2] = 18'(r1_a01);
                n_v[3] = r1_tr + 18'(rmq_pkg::ONE);
            end
            BR_X: begin
                n_v[0] = clamp_pos(r1_rx);
                n_v[1] = 18'(r1_s01);
                n_v[2] = 18'(r1_s02);
                n_v[3] = 18'(r1_a12);
            end
            BR_Y: begin
                n_v[0] = 18'(r1_s01);
                n_v[1] = clamp_pos(r1_ry);
                n_v[2] = 18'(r1_s12);
                n_v[3] = 18'(r1_a20);
            end
            default: begin
                n_v[0] = 18'(r1_s02);
                n_v[1] = 18'(r1_s12);
                n_v[2] = clamp_pos(r1_rz);
                n_v[3] = 18'(r1_a01);
            end
        endcase
        for (int i = 0; i < 4; i++) begin
            n_side.neg[i] = n_v[i][17];
            n_side.mag[i] = n_v[i][17] ? rmq_pkg::MAG_W'(-n_v[i])
                                       : rmq_pkg::MAG_W'(n_v[i]);
        end
    end

    // stages 2..4: magnitudes, squares, sum (magnitudes stay below 2^17, no prescale)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_side <= n_side;
            r3_side <= r2_side;
            r4_side <= r3_side;
            for (int i = 0; i < 4; i++) begin
                r3_sq[i] <= r2_side.mag[i] * r2_side.mag[i];
            end
            r4_sum <= rmq_pkg::SUM_W'(r3_sq[0]) + rmq_pkg::SUM_W'(r3_sq[1])
                    + rmq_pkg::SUM_W'(r3_sq[2]) + rmq_pkg::SUM_W'(r3_sq[3]);
        end
    end

    assign o_valid = r4_vld;
    assign o_sum   = r4_sum;
    assign o_side  = r4_side;
endmodule

>>> hdl/rmq_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module rmq_sqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [rmq_pkg::SUM_W-1:0] i_sum,
    input  rmq_pkg::t_side            i_side,
    output logic                      o_valid,
    output logic [rmq_pkg::LEN_W-1:0] o_len,
    output rmq_pkg::t_side            o_side
);
    localparam int N = rmq_pkg::SQ_STEPS;

    logic [rmq_pkg::RAD_W-1:0] r_rad  [N];
    logic [rmq_pkg::REM_W-1:0] r_rem  [N];
    logic [rmq_pkg::LEN_W-1:0] r_root [N];
    rmq_pkg::t_side            r_side [N];
    logic [N-1:0]              r_vld;

    for (genvar k = 0; k < N; k++) begin : g_st
        logic [rmq_pkg::RAD_W-1:0] c_rad;
        logic [rmq_pkg::REM_W-1:0] c_rem, c_cur, c_trial;
        logic [rmq_pkg::LEN_W-1:0] c_root;
        rmq_pkg::t_side            c_side;
        logic                      c_vld;

        if (k == 0) begin : g_head
            assign c_rad  = {i_sum, (2 * rmq_pkg::LEN_GUARD)'(0)};
            assign c_rem  = '0;
            assign c_root = '0;
            assign c_side = i_side;
            assign c_vld  = i_valid;
        end else begin : g_body
            assign c_rad  = r_rad[k-1];
            assign c_rem  = r_rem[k-1];
            assign c_root = r_root[k-1];
            assign c_side = r_side[k-1];
            assign c_vld  = r_vld[k-1];
        end

        assign c_cur   = {c_rem[rmq_pkg::REM_W-3:0], c_rad[rmq_pkg::RAD_W-1 -: 2]};
        assign c_trial = rmq_pkg::REM_W'({c_root, 2'b01});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= c_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= c_rad << 2;
                r_side[k] <= c_side;
                if (c_cur >= c_trial) begin
                    r_rem[k]  <= c_cur - c_trial;
                    r_root[k] <= {c_root[rmq_pkg::LEN_W-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= c_cur;
                    r_root[k] <= {c_root[rmq_pkg::LEN_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_len   = r_root[N-1];
    assign o_side  = r_side[N-1];
endmodule

>>> hdl/rmq_div.sv
// Four pipelined restoring dividers with rounding, sign and clamp.
module rmq_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [rmq_pkg::LEN_W-1:0] i_len,
    input  rmq_pkg::t_side            i_side,
    output logic                      o_valid,
    output logic signed [15:0]        o_q [4]
);
    localparam int N = rmq_pkg::Q_W;
    localparam int W = rmq_pkg::NUM_W;

    logic [W-1:0]              r_rem [N+1][4];
    logic [N-1:0]              r_quo [N+1][4];
    logic [rmq_pkg::LEN_W-1:0] r_len [N+1];
    logic [3:0]                r_neg [N+1];
    logic [N:0]                r_vld;
    logic                      r_out_vld;
    logic signed [15:0]        r_q [4];
    logic [rmq_pkg::LEN_W-1:0] n_len;

    assign n_len = (i_len == '0) ? rmq_pkg::LEN_W'(1) : i_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_vld     <= {r_vld[N-1:0], i_valid};
            r_out_vld <= r_vld[N];
        end
    end

    // numerator with half the divisor added for rounding
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len[0] <= n_len;
            r_neg[0] <= i_side.neg;
            for (int i = 0; i < 4; i++) begin
                r_rem[0][i] <= (W'(i_side.mag[i]) << (rmq_pkg::FRAC_BITS + rmq_pkg::LEN_GUARD))
                             + W'(n_len >> 1);
                r_quo[0][i] <= '0;
            end
        end
    end

    for (genvar k = 1; k <= N; k++) begin : g_st
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_len[k] <= r_len[k-1];
                r_neg[k] <= r_neg[k-1];
                for (int i = 0; i < 4; i++) begin
                    if (r_rem[k-1][i] >= (W'(r_len[k-1]) << (N - k))) begin
                        r_rem[k][i] <= r_rem[k-1][i] - (W'(r_len[k-1]) << (N - k));
                        r_quo[k][i] <= r_quo[k-1][i] | (N'(1) << (N - k));
                    end else begin
                        r_rem[k][i] <= r_rem[k-1][i];
                        r_quo[k][i] <= r_quo[k-1][i];
                    end
                end
            end
        end
    end

    // clamp to one, restore the sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                logic [N-1:0] m;
                m = (r_quo[N][i] > N'(rmq_pkg::ONE)) ? N'(rmq_pkg::ONE) : r_quo[N][i];
                r_q[i] <= r_neg[N][i] ? -16'(m) : 16'(m);
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_q     = r_q;
endmodule

>>> hdl/rotation_matrix_to_quaternion_core.sv
// Rotation matrix to unit quaternion, Shepperd's branch choice, Q2.14.
// Input channel i_in: one request carries the nine matrix elements e00..e22.
// Output channel o_out: one request carries qx, qy, qz, qw, normalized.
// Pipeline: 49 register stages (4 front, 28 root, 17 divider).
// Throughput: one matrix per cycle unless o_out stalls; the root and the
//   four dividers are fully pipelined, one bit per stage.
// Stall: the whole pipeline holds while a result waits on o_out, and
//   i_in.ready drops with it; nothing is lost or repeated. Ready is high
//   whenever the output register is empty or being drained.
// Reset: i_rst_n synchronous, active low, clears all valid bits; data
//   registers are not reset. No configuration.
module rotation_matrix_to_quaternion_core (
    input  logic i_clk,
    input  logic i_rst_n,
    rmq_in_if.sink    i_in,
    rmq_out_if.source o_out
);
    logic                      w_en;
    logic                      w_f_vld, w_s_vld, w_d_vld;
    logic [rmq_pkg::SUM_W-1:0] w_sum;
    logic [rmq_pkg::LEN_W-1:0] w_len;
    rmq_pkg::t_side            w_f_side, w_s_side;
    logic signed [15:0]        w_q [4];

    // global advance: move when the last stage is empty or taken
    assign w_en       = !w_d_vld || o_out.ready;
    assign i_in.ready = w_en;

    // branch select, |v| split, squares, sum of squares
    rmq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_e00   (i_in.e00), .i_e01 (i_in.e01), .i_e02 (i_in.e02),
        .i_e10   (i_in.e10), .i_e11 (i_in.e11), .i_e12 (i_in.e12),
        .i_e20   (i_in.e20), .i_e21 (i_in.e21), .i_e22 (i_in.e22),
        .o_valid (w_f_vld),
        .o_sum   (w_sum),
        .o_side  (w_f_side)
    );

    // length = floor(sqrt(sum * 2^20))
    rmq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_vld),
        .i_sum   (w_sum),
        .i_side  (w_f_side),
        .o_valid (w_s_vld),
        .o_len   (w_len),
        .o_side  (w_s_side)
    );

    // rounded |v| * 2^24 / length per component
    rmq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_vld),
        .i_len   (w_len),
        .i_side  (w_s_side),
        .o_valid (w_d_vld),
        .o_q     (w_q)
    );

    assign o_out.valid = w_d_vld;
    assign o_out.qx    = w_q[0];
    assign o_out.qy    = w_q[1];
    assign o_out.qz    = w_q[2];
    assign o_out.qw    = w_q[3];
endmodule

>>> hdl/rmq_checker.sv
`include "rotation_matrix_to_quaternion_core_assert.svh"

module rmq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] i_qx,
    input logic signed [15:0] i_qy,
    input logic signed [15:0] i_qz,
    input logic signed [15:0] i_qw
);
    logic        w_stall;
    logic        w_drain;
    logic [63:0] w_q;
    logic        w_in_range;

    assign w_stall    = i_out_valid && !i_out_ready;
    assign w_drain    = !i_out_valid || i_out_ready;
    assign w_q        = {i_qx, i_qy, i_qz, i_qw};
    assign w_in_range = (i_qx <= 16'sd16384) && (i_qx >= -16'sd16384)
                     && (i_qy <= 16'sd16384) && (i_qy >= -16'sd16384)
                     && (i_qz <= 16'sd16384) && (i_qz >= -16'sd16384)
                     && (i_qw <= 16'sd16384) && (i_qw >= -16'sd16384);

    `RMQ_ASSERT(a_out_hold, w_stall |=> i_out_valid && $stable(w_q), "stalled result changed")
    `RMQ_ASSERT(a_ready, i_in_ready == w_drain, "input ready does not follow output drain")
    `RMQ_ASSERT(a_range, i_out_valid |-> w_in_range, "component beyond unit range")
    `RMQ_ASSERT_ALWAYS(a_rst, !i_rst_n |=> !i_out_valid, "result valid right after reset")
endmodule

bind rotation_matrix_to_quaternion_core rmq_checker u_rmq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_qx        (o_out.qx),
    .i_qy        (o_out.qy),
    .i_qz        (o_out.qz),
    .i_qw        (o_out.qw)
);
